FILE: rtl/lsm_pkg.sv
// Shared types, constants and helpers for the latency statistics monitor.
`timescale 1ns / 1ps
package lsm_pkg;

  // Operation entries plus one global entry at index NUM_OPS
  localparam int unsigned NUM_OPS = 16;
  localparam int unsigned ENTRIES = NUM_OPS + 1;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned SUM_W  = 56;
  localparam int unsigned DUR_W  = 40;
  localparam int unsigned REL_W  = 17;
  localparam int unsigned OP_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W  = 40;

  // Result status codes
  typedef enum logic [1:0] {
    ST_RECORDED = 2'd0,
    ST_NOT_MON  = 2'd1,
    ST_INVALID  = 2'd2,
    ST_READ     = 2'd3
  } status_e;

  // Threshold classes
  typedef enum logic [1:0] {
    LVL_BELOW    = 2'd0,
    LVL_WARNING  = 2'd1,
    LVL_CRITICAL = 2'd2
  } level_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MON_EN   = 3'd0,
    CFG_FILT_EN  = 3'd1,
    CFG_OP_MASK  = 3'd2,
    CFG_WARN_LIM = 3'd3,
    CFG_CRIT_LIM = 3'd4
  } cfg_idx_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the transaction and its decision
    logic update;     // read entry, compute new counts into working regs
    logic div_start;  // launch both dividers
    logic write_back; // store working regs into the entry
    logic load_out;   // load the result registers
    logic sel_global; // address the global entry
  } lsm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_record; // latched transaction updates the stores
    logic div_busy;  // a divider is still iterating
  } lsm_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
    sat_inc32 = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

FILE: rtl/lsm_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lsm_div
  import lsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic [SUM_W-1:0] quotient_o,
  output logic             busy_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              run_q, run_d;
  logic [CNT_W:0]    rem_sh;

  // One shift and trial subtract per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    step_d = step_q;
    run_d  = run_q;
    rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[SUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d    = rem_sh - {1'b0, dsr_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = rem_sh;
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SUM_W - 1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign busy_o     = run_q;

endmodule

FILE: rtl/lsm_ctrl.sv
// Sequencing state machine of the latency statistics monitor.
`timescale 1ns / 1ps
module lsm_ctrl
  import lsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  lsm_sts_t sts_i,
  output lsm_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_UPD   = 6'b000010,
    S_DIVGO = 6'b000100,
    S_DIVW  = 6'b001000,
    S_WB    = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   glob_q, glob_d;
  logic   done_q, done_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    glob_d  = glob_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.sel_global = glob_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // records go through the global entry first, then their own entry
          cmd_o.capture = 1'b1;
          glob_d  = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        // decision is latched by now; reads and drops go straight to the result
        if (!sts_i.is_record) begin
          glob_d  = 1'b0;
          state_d = S_OUT;
        end else begin
          cmd_o.update = 1'b1;
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (!sts_i.div_busy) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.write_back = 1'b1;
        if (glob_q) begin
          glob_d  = 1'b0;
          state_d = S_UPD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.load_out = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      glob_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      glob_q  <= glob_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

FILE: rtl/lsm_dp.sv
// Statistics stores, update arithmetic and result registers.
`timescale 1ns / 1ps
module lsm_dp
  import lsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 kind_i,
  input  logic [OP_W-1:0]      op_type_i,
  input  logic [DUR_W-1:0]     duration_i,
  input  logic                 succeeded_i,
  input  lsm_cmd_t             cmd_i,
  output lsm_sts_t             sts_o,
  output logic [1:0]           status_o,
  output logic [1:0]           threshold_level_o,
  output logic [CNT_W-1:0]     call_total_o,
  output logic [CNT_W-1:0]     completed_total_o,
  output logic [CNT_W-1:0]     success_run_o,
  output logic [CNT_W-1:0]     best_run_o,
  output logic [SUM_W-1:0]     duration_sum_o,
  output logic [DUR_W-1:0]     min_duration_o,
  output logic [DUR_W-1:0]     max_duration_o,
  output logic [DUR_W-1:0]     mean_duration_o,
  output logic [REL_W-1:0]     reliability_o
);

  // Configuration registers
  logic             mon_en_q, filt_en_q;
  logic [31:0]      mask_q;
  logic [DUR_W-1:0] warn_q, crit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_en_q  <= 1'b1;
      filt_en_q <= 1'b0;
      mask_q    <= '0;
      warn_q    <= '0;
      crit_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MON_EN:   mon_en_q  <= cfg_data_i[0];
        CFG_FILT_EN:  filt_en_q <= cfg_data_i[0];
        CFG_OP_MASK:  mask_q    <= cfg_data_i[31:0];
        CFG_WARN_LIM: warn_q    <= cfg_data_i[DUR_W-1:0];
        CFG_CRIT_LIM: crit_q    <= cfg_data_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Decision for the incoming transaction
  status_e dec;
  always_comb begin
    if (kind_i) begin
      dec = (op_type_i > OP_W'(NUM_OPS)) ? ST_INVALID : ST_READ;
    end else if (!mon_en_q) begin
      dec = ST_NOT_MON;
    end else if (filt_en_q && (op_type_i >= OP_W'(NUM_OPS) || !mask_q[op_type_i])) begin
      dec = ST_NOT_MON;
    end else if (op_type_i >= OP_W'(NUM_OPS)) begin
      dec = ST_INVALID;
    end else begin
      dec = ST_RECORDED;
    end
  end

  // Latched transaction
  status_e          st_q;
  logic [OP_W-1:0]  op_q;
  logic [DUR_W-1:0] dur_q;
  logic             ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      st_q  <= dec;
      op_q  <= op_type_i;
      dur_q <= duration_i;
      ok_q  <= succeeded_i;
    end
  end

  // Statistics stores
  logic [CNT_W-1:0] call_q [ENTRIES];
  logic [CNT_W-1:0] comp_q [ENTRIES];
  logic [CNT_W-1:0] run_q  [ENTRIES];
  logic [CNT_W-1:0] best_q [ENTRIES];
  logic [SUM_W-1:0] sum_q  [ENTRIES];
  logic [DUR_W-1:0] min_q  [ENTRIES];
  logic [DUR_W-1:0] max_q  [ENTRIES];
  logic [DUR_W-1:0] mean_q [ENTRIES];
  logic [REL_W-1:0] rel_q  [ENTRIES];

  logic [IDX_W-1:0] idx;
  assign idx = cmd_i.sel_global ? IDX_W'(NUM_OPS) : op_q[IDX_W-1:0];

  // Updated values of the addressed entry
  logic [CNT_W-1:0] call_n, comp_n, run_n, best_n;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_n;
  logic [DUR_W-1:0] min_n, max_n;

  always_comb begin
    call_n   = sat_inc32(call_q[idx]);
    comp_n   = ok_q ? sat_inc32(comp_q[idx]) : comp_q[idx];
    run_n    = ok_q ? sat_inc32(run_q[idx]) : '0;
    best_n   = (ok_q && run_n > best_q[idx]) ? run_n : best_q[idx];
    sum_wide = {1'b0, sum_q[idx]} + {{(SUM_W+1-DUR_W){1'b0}}, dur_q};
    sum_n    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    min_n    = (dur_q < min_q[idx]) ? dur_q : min_q[idx];
    max_n    = (dur_q > max_q[idx]) ? dur_q : max_q[idx];
  end

  // Working registers
  logic [CNT_W-1:0] w_call_q, w_comp_q, w_run_q, w_best_q;
  logic [SUM_W-1:0] w_sum_q;
  logic [DUR_W-1:0] w_min_q, w_max_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      w_call_q <= call_n;
      w_comp_q <= comp_n;
      w_run_q  <= run_n;
      w_best_q <= best_n;
      w_sum_q  <= sum_n;
      w_min_q  <= min_n;
      w_max_q  <= max_n;
    end
  end

  // Mean and reliability dividers
  logic [SUM_W-1:0] mean_quo, rel_quo;
  logic             mean_busy, rel_busy;

  lsm_div u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (w_sum_q),
    .divisor_i  (w_comp_q),
    .quotient_o (mean_quo),
    .busy_o     (mean_busy)
  );

  lsm_div u_rel_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({{(SUM_W-CNT_W-16){1'b0}}, w_comp_q, 16'b0}),
    .divisor_i  (w_call_q),
    .quotient_o (rel_quo),
    .busy_o     (rel_busy)
  );

  logic [DUR_W-1:0] mean_n;
  always_comb begin
    if (w_comp_q == '0) mean_n = mean_q[idx];
    else if (mean_quo[SUM_W-1:DUR_W] != '0) mean_n = {DUR_W{1'b1}};
    else mean_n = mean_quo[DUR_W-1:0];
  end

  // Store write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        call_q[i] <= '0;
        comp_q[i] <= '0;
        run_q[i]  <= '0;
        best_q[i] <= '0;
        sum_q[i]  <= '0;
        min_q[i]  <= {DUR_W{1'b1}};
        max_q[i]  <= '0;
        mean_q[i] <= '0;
        rel_q[i]  <= '0;
      end
    end else if (cmd_i.write_back) begin
      call_q[idx] <= w_call_q;
      comp_q[idx] <= w_comp_q;
      run_q[idx]  <= w_run_q;
      best_q[idx] <= w_best_q;
      sum_q[idx]  <= w_sum_q;
      min_q[idx]  <= w_min_q;
      max_q[idx]  <= w_max_q;
      mean_q[idx] <= mean_n;
      rel_q[idx]  <= rel_quo[REL_W-1:0];
    end
  end

  // Result registers
  logic   show;
  level_e lvl;
  assign show = (st_q == ST_RECORDED) || (st_q == ST_READ);

  always_comb begin
    if (st_q != ST_RECORDED) lvl = LVL_BELOW;
    else if (dur_q >= crit_q) lvl = LVL_CRITICAL;
    else if (dur_q >= warn_q) lvl = LVL_WARNING;
    else lvl = LVL_BELOW;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o          <= st_q;
      threshold_level_o <= lvl;
      call_total_o      <= show ? call_q[idx] : '0;
      completed_total_o <= show ? comp_q[idx] : '0;
      success_run_o     <= show ? run_q[idx]  : '0;
      best_run_o        <= show ? best_q[idx] : '0;
      duration_sum_o    <= show ? sum_q[idx]  : '0;
      min_duration_o    <= show ? min_q[idx]  : '0;
      max_duration_o    <= show ? max_q[idx]  : '0;
      mean_duration_o   <= show ? mean_q[idx] : '0;
      reliability_o     <= show ? rel_q[idx]  : '0;
    end
  end

  assign sts_o.is_record = (st_q == ST_RECORDED);
  assign sts_o.div_busy  = mean_busy || rel_busy;

endmodule

FILE: rtl/latency_statistics_monitor_unit.sv
// Top level of the latency statistics monitor.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  command  | start_i, busy_o      | kind_i, op_type_i, duration_i, succeeded_i
//  result   | done_o (1 cycle)     | status_o .. reliability_o
//  config   | cfg_we_i, cfg_idx_i  | cfg_data_i
//
// A read or dropped transaction passes the update state and then loads the
// result registers, which raises the done strobe. A recorded transaction
// updates the global and then the operation entry, each by update, divider
// launch, 56-step serial mean and reliability division, a wait to see it end
// and write back; then the result registers are loaded.
// Reset clears all stores at once; no clearing pass follows.
// The receiver cannot stall; busy_o is high from acceptance until the strobe.
`timescale 1ns / 1ps
module latency_statistics_monitor_unit
  import lsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 kind_i,
  input  logic [OP_W-1:0]      op_type_i,
  input  logic [DUR_W-1:0]     duration_i,
  input  logic                 succeeded_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [1:0]           threshold_level_o,
  output logic [CNT_W-1:0]     call_total_o,
  output logic [CNT_W-1:0]     completed_total_o,
  output logic [CNT_W-1:0]     success_run_o,
  output logic [CNT_W-1:0]     best_run_o,
  output logic [SUM_W-1:0]     duration_sum_o,
  output logic [DUR_W-1:0]     min_duration_o,
  output logic [DUR_W-1:0]     max_duration_o,
  output logic [DUR_W-1:0]     mean_duration_o,
  output logic [REL_W-1:0]     reliability_o
);

  lsm_cmd_t cmd;
  lsm_sts_t sts;

  lsm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  lsm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .op_type_i         (op_type_i),
    .duration_i        (duration_i),
    .succeeded_i       (succeeded_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .threshold_level_o (threshold_level_o),
    .call_total_o      (call_total_o),
    .completed_total_o (completed_total_o),
    .success_run_o     (success_run_o),
    .best_run_o        (best_run_o),
    .duration_sum_o    (duration_sum_o),
    .min_duration_o    (min_duration_o),
    .max_duration_o    (max_duration_o),
    .mean_duration_o   (mean_duration_o),
    .reliability_o     (reliability_o)
  );

endmodule

FILE: rtl/lsm_checker.sv
// Port-level checker for the latency statistics monitor, with its bind.
`timescale 1ns / 1ps
module lsm_checker
  import lsm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             done_o,
  input logic [1:0]       status_o,
  input logic [1:0]       threshold_level_o,
  input logic [CNT_W-1:0] call_total_o
);

  // Accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accept did not raise busy");

  // Strobe lasts one cycle and the block is free during it
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy during result strobe");

  // Only recorded transactions carry a threshold level
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_RECORDED |-> threshold_level_o == LVL_BELOW)
    else $error("threshold level on non-record result");

  // Dropped and invalid results carry no statistics
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_NOT_MON || status_o == ST_INVALID) |-> call_total_o == '0)
    else $error("statistics on dropped result");

endmodule

bind latency_statistics_monitor_unit lsm_checker u_lsm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .status_o          (status_o),
  .threshold_level_o (threshold_level_o),
  .call_total_o      (call_total_o)
);

FILE: tb/sv/tb_latency_statistics_monitor_unit.sv
// Self-checking testbench for the latency statistics monitor top level.
`timescale 1ns / 1ps
module tb_latency_statistics_monitor_unit
  import lsm_pkg::*;
;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};
  localparam logic [OP_W-1:0]  OP_GLOBAL = OP_W'(NUM_OPS);
  localparam bit KIND_RECORD = 1'b0;
  localparam bit KIND_READ   = 1'b1;

  // One result transaction as seen on the result ports
  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       level;
    logic [CNT_W-1:0] calls;
    logic [CNT_W-1:0] completed;
    logic [CNT_W-1:0] run;
    logic [CNT_W-1:0] best;
    logic [SUM_W-1:0] sum;
    logic [DUR_W-1:0] min_d;
    logic [DUR_W-1:0] max_d;
    logic [DUR_W-1:0] mean_d;
    logic [REL_W-1:0] rel;
  } stats_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic kind_i = 1'b0;
  logic [OP_W-1:0] op_type_i = '0;
  logic [DUR_W-1:0] duration_i = '0;
  logic succeeded_i = 1'b0;
  logic done_o;
  logic [1:0] status_o, threshold_level_o;
  logic [CNT_W-1:0] call_total_o, completed_total_o, success_run_o, best_run_o;
  logic [SUM_W-1:0] duration_sum_o;
  logic [DUR_W-1:0] min_duration_o, max_duration_o, mean_duration_o;
  logic [REL_W-1:0] reliability_o;

  latency_statistics_monitor_unit dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // Predictor state
  logic             mon_en_q, filt_en_q;
  logic [31:0]      mask_q;
  logic [DUR_W-1:0] warn_q, crit_q;
  logic [CNT_W-1:0] calls_q [ENTRIES];
  logic [CNT_W-1:0] compl_q [ENTRIES];
  logic [CNT_W-1:0] run_q   [ENTRIES];
  logic [CNT_W-1:0] best_q  [ENTRIES];
  logic [SUM_W-1:0] sum_q   [ENTRIES];
  logic [DUR_W-1:0] min_q   [ENTRIES];
  logic [DUR_W-1:0] max_q   [ENTRIES];
  logic [DUR_W-1:0] mean_q  [ENTRIES];
  logic [REL_W-1:0] rel_q   [ENTRIES];

  stats_result_t pending_results [$];
  int unsigned errors = 0, n_sent = 0, n_checked = 0, n_recorded = 0, cycles = 0;

  task automatic clear_stats();
    mon_en_q = 1'b1; filt_en_q = 1'b0; mask_q = '0; warn_q = '0; crit_q = '0;
    for (int e = 0; e < ENTRIES; e++) begin
      calls_q[e] = '0; compl_q[e] = '0; run_q[e] = '0; best_q[e] = '0;
      sum_q[e] = '0; min_q[e] = DUR_MAX; max_q[e] = '0; mean_q[e] = '0; rel_q[e] = '0;
    end
  endtask

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic fold_measurement(input int e, input logic [DUR_W-1:0] d, input bit ok);
    logic [SUM_W:0] s;
    logic [SUM_W-1:0] m;
    calls_q[e] = bump(calls_q[e]);
    if (ok) begin
      compl_q[e] = bump(compl_q[e]);
      run_q[e] = bump(run_q[e]);
      if (run_q[e] > best_q[e]) best_q[e] = run_q[e];
    end else begin
      run_q[e] = '0;
    end
    s = sum_q[e] + d;
    sum_q[e] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    if (d < min_q[e]) min_q[e] = d;
    if (d > max_q[e]) max_q[e] = d;
    if (compl_q[e] != 0) begin
      m = sum_q[e] / compl_q[e];
      mean_q[e] = (m > DUR_MAX) ? DUR_MAX : m[DUR_W-1:0];
    end
    if (calls_q[e] != 0) rel_q[e] = REL_W'(({16'd0, compl_q[e]} << 16) / calls_q[e]);
  endtask

  function automatic stats_result_t entry_view(input int e);
    stats_result_t r;
    r = '0;
    r.calls = calls_q[e]; r.completed = compl_q[e]; r.run = run_q[e]; r.best = best_q[e];
    r.sum = sum_q[e]; r.min_d = min_q[e]; r.max_d = max_q[e]; r.mean_d = mean_q[e];
    r.rel = rel_q[e];
    return r;
  endfunction

  // Work out the result of one command transaction and advance the state
  task automatic predict_stats(input bit kind, input logic [OP_W-1:0] op,
                               input logic [DUR_W-1:0] d, input bit ok);
    stats_result_t r;
    r = '0;
    if (kind == KIND_READ) begin
      if (op > NUM_OPS) r.status = ST_INVALID;
      else begin
        r = entry_view(op);
        r.status = ST_READ;
      end
    end else if (!mon_en_q) r.status = ST_NOT_MON;
    else if (filt_en_q && (op >= NUM_OPS || !mask_q[op])) r.status = ST_NOT_MON;
    else if (op >= NUM_OPS) r.status = ST_INVALID;
    else begin
      fold_measurement(NUM_OPS, d, ok);
      fold_measurement(op, d, ok);
      r = entry_view(op);
      r.status = ST_RECORDED;
      r.level = (d >= crit_q) ? LVL_CRITICAL : (d >= warn_q) ? LVL_WARNING : LVL_BELOW;
      n_recorded++;
    end
    pending_results.push_back(r);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Issue one command; the gap before it is drawn at random
  task automatic send_cmd(input bit kind, input logic [OP_W-1:0] op,
                          input logic [DUR_W-1:0] d, input bit ok);
    idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
    while (busy_o) @(posedge clk_i);
    start_i <= 1'b1; kind_i <= kind; op_type_i <= op; duration_i <= d; succeeded_i <= ok;
    predict_stats(kind, op, d, ok);
    n_sent++;
    @(posedge clk_i);
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    idle_cycles(10);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_W-1:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MON_EN:   mon_en_q = v[0];
      CFG_FILT_EN:  filt_en_q = v[0];
      CFG_OP_MASK:  mask_q = v[31:0];
      CFG_WARN_LIM: warn_q = v[DUR_W-1:0];
      CFG_CRIT_LIM: crit_q = v[DUR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [DUR_W-1:0] rand_dur();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return DUR_MAX - DUR_W'($urandom_range(0, 3));
      1: return wide[DUR_W-1:0];
      2: return DUR_W'($urandom_range(0, 20));
      default: return DUR_W'($urandom_range(0, 100_000));
    endcase
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    stats_result_t got, want;
    if (rst_ni && done_o) begin
      got = {status_o, threshold_level_o, call_total_o, completed_total_o, success_run_o,
             best_run_o, duration_sum_o, min_duration_o, max_duration_o,
             mean_duration_o, reliability_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch status exp %0d act %0d, level exp %0d act %0d", $time,
                   want.status, got.status, want.level, got.level);
          $display("  calls %0d/%0d compl %0d/%0d run %0d/%0d best %0d/%0d",
                   want.calls, got.calls, want.completed, got.completed,
                   want.run, got.run, want.best, got.best);
          $display("  sum %0d/%0d min %0d/%0d max %0d/%0d mean %0d/%0d rel %0d/%0d",
                   want.sum, got.sum, want.min_d, got.min_d, want.max_d, got.max_d,
                   want.mean_d, got.mean_d, want.rel, got.rel);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_latency_statistics_monitor_unit: FAIL");
      $finish;
    end
  end

  // Extremes, every status and level, reads of the global entry, of one operation entry and of invalid indexes
  task automatic test_directed();
    send_cmd(KIND_READ, OP_GLOBAL, '0, 1'b0);
    send_cmd(KIND_READ, 5'd31, DUR_MAX, 1'b1);
    send_cmd(KIND_RECORD, 5'd0, '0, 1'b1);
    send_cmd(KIND_RECORD, 5'd15, DUR_MAX, 1'b1);
    send_cmd(KIND_RECORD, 5'd15, DUR_MAX, 1'b0);
    send_cmd(KIND_RECORD, 5'd16, 40'd5, 1'b1);
    send_cmd(KIND_RECORD, 5'd31, 40'd5, 1'b1);
    send_cmd(KIND_READ, 5'd15, '0, 1'b0);
    send_cmd(KIND_READ, 5'd17, '0, 1'b0);
    drain();
    write_cfg(CFG_WARN_LIM, 40'd100);
    write_cfg(CFG_CRIT_LIM, 40'd1000);
    send_cmd(KIND_RECORD, 5'd3, 40'd99, 1'b1);
    send_cmd(KIND_RECORD, 5'd3, 40'd100, 1'b1);
    send_cmd(KIND_RECORD, 5'd3, 40'd1000, 1'b0);
    drain();
    write_cfg(CFG_CRIT_LIM, 40'd50);  // critical below warning
    send_cmd(KIND_RECORD, 5'd4, 40'd60, 1'b1);
    drain();
    write_cfg(CFG_MON_EN, 40'd0);
    send_cmd(KIND_RECORD, 5'd2, 40'd7, 1'b1);
    send_cmd(KIND_READ, OP_GLOBAL, '0, 1'b0);
    drain();
    write_cfg(CFG_MON_EN, 40'd1);
    write_cfg(CFG_FILT_EN, 40'd1);
    write_cfg(CFG_OP_MASK, 40'h0000_0001_0005);
    send_cmd(KIND_RECORD, 5'd0, 40'd8, 1'b1);
    send_cmd(KIND_RECORD, 5'd1, 40'd8, 1'b1);
    send_cmd(KIND_RECORD, 5'd16, 40'd8, 1'b1);
    drain();
    write_cfg(CFG_FILT_EN, 40'd0);
    write_cfg(CFG_WARN_LIM, DUR_MAX);
    write_cfg(CFG_CRIT_LIM, DUR_MAX);
    send_cmd(KIND_RECORD, 5'd1, DUR_MAX, 1'b1);
    drain();
  endtask

  // Random phases over several register settings
  task automatic test_random(input int items);
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_MON_EN, (ph == 2) ? 40'd0 : 40'd1);
      write_cfg(CFG_FILT_EN, (ph >= 3) ? 40'd1 : 40'd0);
      write_cfg(CFG_OP_MASK, (ph == 5) ? 40'hFFFF_FFFF : {8'd0, $urandom});
      write_cfg(CFG_WARN_LIM, (ph == 4) ? '0 : 40'($urandom_range(0, 60_000)));
      write_cfg(CFG_CRIT_LIM, (ph == 0) ? DUR_MAX : 40'($urandom_range(0, 120_000)));
      for (int i = 0; i < items / 6; i++) begin
        bit kind;
        logic [OP_W-1:0] op;
        kind = ($urandom_range(0, 4) == 0);
        op = ($urandom_range(0, 9) == 0) ? OP_W'($urandom) : OP_W'($urandom_range(0, 15));
        if (kind && $urandom_range(0, 2) == 0) op = OP_GLOBAL;
        send_cmd(kind, op, rand_dur(), $urandom_range(0, 3) != 0);
      end
      drain();
    end
  endtask

  initial begin
    clear_stats();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1800);
    drain();
    $display("Sent %0d commands, %0d recorded measurements, %0d results checked.",
             n_sent, n_recorded, n_checked);
    $display("Covered dropped, filtered, invalid and read paths over six settings.");
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_latency_statistics_monitor_unit: PASS");
    else
      $display("tb_latency_statistics_monitor_unit: FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/lsm_pkg.sv
rtl/lsm_div.sv
rtl/lsm_ctrl.sv
rtl/lsm_dp.sv
rtl/latency_statistics_monitor_unit.sv
rtl/lsm_checker.sv
tb/sv/tb_latency_statistics_monitor_unit.sv
